// File: src/title_format_char_lexer_assert.svh
// ----------------------------------------------------------------------------
// Title-format lexer assertion macros
// Shorthand for clocked implication checks, reset-qualified on rst_n.
// ----------------------------------------------------------------------------
`ifndef TITLE_FORMAT_CHAR_LEXER_ASSERT_SVH
`define TITLE_FORMAT_CHAR_LEXER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TFCL_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TFCL_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tfcl_pkg.sv
// ----------------------------------------------------------------------------
// Title-format lexer package
// Token kinds, error codes, lexer modes, special characters and queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

package tfcl_pkg;

  localparam int DEPTH_BITS  = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] MODE_TEXT  = 2'd0;
  localparam logic [1:0] MODE_FIELD = 2'd1;
  localparam logic [1:0] MODE_FNAME = 2'd2;
  localparam logic [1:0] MODE_RAW   = 2'd3;

  localparam logic [3:0] TK_TEXT        = 4'd0;
  localparam logic [3:0] TK_FIELD_BEGIN = 4'd1;
  localparam logic [3:0] TK_FIELD_NAME  = 4'd2;
  localparam logic [3:0] TK_FIELD_END   = 4'd3;
  localparam logic [3:0] TK_FUNC_SYMBOL = 4'd4;
  localparam logic [3:0] TK_FUNC_NAME   = 4'd5;
  localparam logic [3:0] TK_FUNC_BEGIN  = 4'd6;
  localparam logic [3:0] TK_DELIMITER   = 4'd7;
  localparam logic [3:0] TK_FUNC_END    = 4'd8;
  localparam logic [3:0] TK_RAW_BEGIN   = 4'd9;
  localparam logic [3:0] TK_RAW_END     = 4'd10;
  localparam logic [3:0] TK_COND_BEGIN  = 4'd11;
  localparam logic [3:0] TK_COND_END    = 4'd12;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_OPEN_FIELD = 3'd1;
  localparam logic [2:0] ERR_OPEN_FNAME = 3'd2;
  localparam logic [2:0] ERR_OPEN_RAW   = 3'd3;
  localparam logic [2:0] ERR_UNCLOSED   = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW   = 3'd5;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] ch;
    logic       start;
    logic [2:0] err;
    logic       dbl;
  } tfcl_entry_t;

endpackage

`default_nettype wire

// File: src/tfcl_front.sv
// ----------------------------------------------------------------------------
// Title-format lexer front end
// Classifies each character, keeps the lexer state and queues the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tfcl_front #(
  parameter int DEPTH_BITS = tfcl_pkg::DEPTH_BITS
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  [7:0]           in_char,
  input  wire                  in_last,
  output logic                 push,
  output tfcl_pkg::tfcl_entry_t push_data,
  input  wire                  q_full
);

  logic [1:0]            mode_r, mode_nxt, mode_upd;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt, depth_upd;
  logic                  raw_empty_r, raw_empty_nxt, raw_empty_upd;
  logic                  in_run_r, in_run_nxt, in_run_upd;
  logic                  ovf_r, ovf_nxt, ovf_upd;
  logic                  accept;
  logic [3:0]            kind;
  logic                  start;
  logic                  dbl;
  logic [2:0]            err;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    kind          = tfcl_pkg::TK_TEXT;
    start         = 1'b1;
    dbl           = 1'b0;
    mode_upd      = mode_r;
    depth_upd     = depth_r;
    raw_empty_upd = raw_empty_r;
    in_run_upd    = 1'b0;
    ovf_upd       = ovf_r;
    unique case (mode_r)
      tfcl_pkg::MODE_TEXT: begin
        if (in_char == tfcl_pkg::CH_PERCENT) begin
          kind     = tfcl_pkg::TK_FIELD_BEGIN;
          mode_upd = tfcl_pkg::MODE_FIELD;
        end else if (in_char == tfcl_pkg::CH_DOLLAR) begin
          kind     = tfcl_pkg::TK_FUNC_SYMBOL;
          mode_upd = tfcl_pkg::MODE_FNAME;
        end else if (in_char == tfcl_pkg::CH_QUOTE) begin
          kind          = tfcl_pkg::TK_RAW_BEGIN;
          mode_upd      = tfcl_pkg::MODE_RAW;
          raw_empty_upd = 1'b1;
        end else if (in_char == tfcl_pkg::CH_LBRACK) begin
          kind = tfcl_pkg::TK_COND_BEGIN;
        end else if (in_char == tfcl_pkg::CH_RBRACK) begin
          kind = tfcl_pkg::TK_COND_END;
        end else if (in_char == tfcl_pkg::CH_COMMA && depth_r != '0) begin
          kind = tfcl_pkg::TK_DELIMITER;
        end else if (in_char == tfcl_pkg::CH_RPAREN && depth_r != '0) begin
          kind      = tfcl_pkg::TK_FUNC_END;
          depth_upd = depth_r - 1'b1;
        end else begin
          kind       = tfcl_pkg::TK_TEXT;
          start      = !in_run_r;
          in_run_upd = 1'b1;
        end
      end
      tfcl_pkg::MODE_FIELD: begin
        if (in_char == tfcl_pkg::CH_PERCENT) begin
          kind     = tfcl_pkg::TK_FIELD_END;
          mode_upd = tfcl_pkg::MODE_TEXT;
        end else begin
          kind       = tfcl_pkg::TK_FIELD_NAME;
          start      = !in_run_r;
          in_run_upd = 1'b1;
        end
      end
      tfcl_pkg::MODE_FNAME: begin
        if (in_char == tfcl_pkg::CH_LPAREN) begin
          kind     = tfcl_pkg::TK_FUNC_BEGIN;
          mode_upd = tfcl_pkg::MODE_TEXT;
          if (&depth_r) begin
            ovf_upd = 1'b1;
          end else begin
            depth_upd = depth_r + 1'b1;
          end
        end else begin
          kind       = tfcl_pkg::TK_FUNC_NAME;
          start      = !in_run_r;
          in_run_upd = 1'b1;
        end
      end
      default: begin
        raw_empty_upd = 1'b0;
        if (in_char == tfcl_pkg::CH_QUOTE) begin
          kind     = tfcl_pkg::TK_RAW_END;
          mode_upd = tfcl_pkg::MODE_TEXT;
          dbl      = raw_empty_r;
        end else begin
          kind       = tfcl_pkg::TK_TEXT;
          start      = !in_run_r;
          in_run_upd = 1'b1;
        end
      end
    endcase

    err = tfcl_pkg::ERR_NONE;
    if (in_last) begin
      if (mode_upd == tfcl_pkg::MODE_FIELD) begin
        err = tfcl_pkg::ERR_OPEN_FIELD;
      end else if (mode_upd == tfcl_pkg::MODE_FNAME) begin
        err = tfcl_pkg::ERR_OPEN_FNAME;
      end else if (mode_upd == tfcl_pkg::MODE_RAW) begin
        err = tfcl_pkg::ERR_OPEN_RAW;
      end else if (ovf_upd) begin
        err = tfcl_pkg::ERR_OVERFLOW;
      end else if (depth_upd != '0) begin
        err = tfcl_pkg::ERR_UNCLOSED;
      end
    end
  end

  always_comb begin
    mode_nxt      = mode_r;
    depth_nxt     = depth_r;
    raw_empty_nxt = raw_empty_r;
    in_run_nxt    = in_run_r;
    ovf_nxt       = ovf_r;
    if (accept) begin
      if (in_last) begin
        mode_nxt      = tfcl_pkg::MODE_TEXT;
        depth_nxt     = '0;
        raw_empty_nxt = 1'b0;
        in_run_nxt    = 1'b0;
        ovf_nxt       = 1'b0;
      end else begin
        mode_nxt      = mode_upd;
        depth_nxt     = depth_upd;
        raw_empty_nxt = raw_empty_upd;
        in_run_nxt    = in_run_upd;
        ovf_nxt       = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= tfcl_pkg::MODE_TEXT;
      depth_r     <= '0;
      raw_empty_r <= 1'b0;
      in_run_r    <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      depth_r     <= depth_nxt;
      raw_empty_r <= raw_empty_nxt;
      in_run_r    <= in_run_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  assign push            = accept;
  assign push_data.kind  = kind;
  assign push_data.ch    = in_char;
  assign push_data.start = start;
  assign push_data.err   = err;
  assign push_data.dbl   = dbl;

endmodule

`default_nettype wire

// File: src/tfcl_queue.sv
// ----------------------------------------------------------------------------
// Title-format lexer queue
// Small first-word-fall-through queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tfcl_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  tfcl_pkg::tfcl_entry_t push_data,
  output logic                  full,
  input  wire                   pop,
  output logic                  empty,
  output tfcl_pkg::tfcl_entry_t head
);

  localparam int PTR_W = $clog2(tfcl_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W:0] CNT_FULL = (PTR_W+1)'(tfcl_pkg::QUEUE_DEPTH);

  tfcl_pkg::tfcl_entry_t mem [tfcl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]        cnt_r, cnt_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: src/tfcl_back.sv
// ----------------------------------------------------------------------------
// Title-format lexer back end
// Drains queued entries into the output register, splitting token pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module tfcl_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_empty,
  input  tfcl_pkg::tfcl_entry_t head,
  output logic                  pop,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [15:0]           out_tdata,
  output logic [4:0]            out_tuser,
  output logic                  out_tlast
);

  logic       valid_r, valid_nxt;
  logic       half_r, half_nxt;
  logic [3:0] kind_r, kind_nxt;
  logic [7:0] ch_r, ch_nxt;
  logic       start_r, start_nxt;
  logic [2:0] err_r, err_nxt;
  logic       last_r, last_nxt;
  logic       load;

  assign load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    half_nxt  = half_r;
    kind_nxt  = kind_r;
    ch_nxt    = ch_r;
    start_nxt = start_r;
    err_nxt   = err_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        err_nxt = head.err;
        if (head.dbl && !half_r) begin
          kind_nxt  = tfcl_pkg::TK_TEXT;
          ch_nxt    = tfcl_pkg::CH_QUOTE;
          start_nxt = 1'b1;
          last_nxt  = 1'b0;
          half_nxt  = 1'b1;
        end else begin
          kind_nxt  = head.kind;
          ch_nxt    = head.ch;
          start_nxt = head.start;
          last_nxt  = 1'b1;
          half_nxt  = 1'b0;
          pop       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    ch_r    <= ch_nxt;
    start_r <= start_nxt;
    err_r   <= err_nxt;
    last_r  <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {5'd0, err_r, ch_r};
  assign out_tuser  = {start_r, kind_r};
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

// File: src/title_format_char_lexer.sv
// ----------------------------------------------------------------------------
// Title-format character lexer
// Tags each character of a title-format string with its token kind.
// ----------------------------------------------------------------------------
// One character is taken per cycle, every cycle, as long as the four-entry
// queue between the front end and the output stage has room. Each result
// is written into the queue and then loaded into the output register. An
// empty quoted pair makes two results, a literal quote and the raw end;
// every other character makes one result. Errors are reported only on the
// results of a character marked with tlast, after which the lexer starts
// the next string from its reset state.
`default_nettype none

module title_format_char_lexer #(
  parameter int DEPTH_BITS = tfcl_pkg::DEPTH_BITS
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] char_value
  input  wire         in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_char, [10:8] error_code, [15:11] zero
  output logic [4:0]  out_tuser,  // [3:0] token_kind, [4] token_start
  output logic        out_tlast   // run_last
);

  logic                  push;
  tfcl_pkg::tfcl_entry_t push_data;
  logic                  q_full;
  logic                  q_empty;
  logic                  pop;
  tfcl_pkg::tfcl_entry_t head;

  tfcl_front #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_char  (in_tdata),
    .in_last  (in_tlast),
    .push     (push),
    .push_data(push_data),
    .q_full   (q_full)
  );

  tfcl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  tfcl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

`default_nettype wire

// File: src/tfcl_checker.sv
// ----------------------------------------------------------------------------
// Title-format lexer checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "title_format_char_lexer_assert.svh"

module tfcl_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [15:0] out_tdata,
  input wire [4:0]  out_tuser,
  input wire        out_tlast
);

  logic out_xfer;
  logic is_quote_text;

  assign out_xfer      = out_tvalid && out_tready;
  assign is_quote_text = (out_tuser[3:0] == tfcl_pkg::TK_TEXT) && out_tuser[4] &&
                         (out_tdata[7:0] == tfcl_pkg::CH_QUOTE);

  `TFCL_ASSERT_NXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result changed while stalled")

  `TFCL_ASSERT_IMP(a_pair_first, out_tvalid && !out_tlast, is_quote_text, "non-final result is not a literal quote")

  `TFCL_ASSERT_NXT(a_pair_second, out_xfer && !out_tlast, out_tvalid && out_tlast && (out_tuser[3:0] == tfcl_pkg::TK_RAW_END), "literal quote not followed by raw end")

  `TFCL_ASSERT_IMP(a_err_range, out_tvalid, (out_tdata[15:11] == 5'd0) && (out_tdata[10:8] != 3'd6) && (out_tdata[10:8] != 3'd7), "bad error code or padding")

endmodule

bind title_format_char_lexer tfcl_checker u_tfcl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

`default_nettype wire

// File: tb/title_format_char_lexer_checker.sv
// ----------------------------------------------------------------------------
// Title-format lexer token checker
// Watches both streams of the lexer, predicts the tagged tokens of every
// accepted character and compares each result transfer with the oldest one.
// ----------------------------------------------------------------------------
module title_format_char_lexer_checker
  import tfcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_value
  input  logic        in_tlast,   // end_of_input
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [7:0] out_char, [10:8] error_code, [15:11] zero
  input  logic [4:0]  out_tuser,  // [3:0] token_kind, [4] token_start
  input  logic        out_tlast,  // run_last
  output int          fail_count,
  output int          expected_left
);

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] ch;
    logic       start;
    logic [2:0] err;
    logic       last;
  } token_t;

  token_t                 token_queue[$];
  logic [1:0]             lex_mode;
  logic [DEPTH_BITS-1:0]  nest_depth;
  logic                   raw_empty;
  logic                   in_run;
  logic                   overflow;

  function automatic token_t make_token(logic [3:0] kind, logic [7:0] ch, logic start);
    token_t t;
    t       = '0;
    t.kind  = kind;
    t.ch    = ch;
    t.start = start;
    return t;
  endfunction

  task automatic clear_lexer();
    lex_mode   = MODE_TEXT;
    nest_depth = '0;
    raw_empty  = 1'b0;
    in_run     = 1'b0;
    overflow   = 1'b0;
  endtask

  task automatic lex_char(input logic [7:0] c, input logic last);
    token_t     first;
    token_t     second;
    logic [2:0] err;
    logic       run_open;
    int         count;
    count    = 1;
    second   = '0;
    run_open = in_run;
    case (lex_mode)
      MODE_TEXT: begin
        in_run = 1'b0;
        if (c == CH_PERCENT) begin
          first    = make_token(TK_FIELD_BEGIN, c, 1'b1);
          lex_mode = MODE_FIELD;
        end else if (c == CH_DOLLAR) begin
          first    = make_token(TK_FUNC_SYMBOL, c, 1'b1);
          lex_mode = MODE_FNAME;
        end else if (c == CH_QUOTE) begin
          first     = make_token(TK_RAW_BEGIN, c, 1'b1);
          lex_mode  = MODE_RAW;
          raw_empty = 1'b1;
        end else if (c == CH_LBRACK) begin
          first = make_token(TK_COND_BEGIN, c, 1'b1);
        end else if (c == CH_RBRACK) begin
          first = make_token(TK_COND_END, c, 1'b1);
        end else if (c == CH_COMMA && nest_depth != 0) begin
          first = make_token(TK_DELIMITER, c, 1'b1);
        end else if (c == CH_RPAREN && nest_depth != 0) begin
          first      = make_token(TK_FUNC_END, c, 1'b1);
          nest_depth = nest_depth - 1'b1;
        end else begin
          // Plain text continues the open run, if there is one.
          first  = make_token(TK_TEXT, c, !run_open);
          in_run = 1'b1;
        end
      end
      MODE_FIELD: begin
        if (c == CH_PERCENT) begin
          first    = make_token(TK_FIELD_END, c, 1'b1);
          lex_mode = MODE_TEXT;
          in_run   = 1'b0;
        end else begin
          first  = make_token(TK_FIELD_NAME, c, !in_run);
          in_run = 1'b1;
        end
      end
      MODE_FNAME: begin
        if (c == CH_LPAREN) begin
          first = make_token(TK_FUNC_BEGIN, c, 1'b1);
          if (nest_depth != '1) begin
            nest_depth = nest_depth + 1'b1;
          end else begin
            overflow = 1'b1;
          end
          lex_mode = MODE_TEXT;
          in_run   = 1'b0;
        end else begin
          first  = make_token(TK_FUNC_NAME, c, !in_run);
          in_run = 1'b1;
        end
      end
      default: begin
        if (c == CH_QUOTE) begin
          if (raw_empty) begin
            // An empty quoted pair stands for one literal quote.
            first  = make_token(TK_TEXT, CH_QUOTE, 1'b1);
            second = make_token(TK_RAW_END, c, 1'b1);
            count  = 2;
          end else begin
            first = make_token(TK_RAW_END, c, 1'b1);
          end
          lex_mode  = MODE_TEXT;
          raw_empty = 1'b0;
          in_run    = 1'b0;
        end else begin
          raw_empty = 1'b0;
          first     = make_token(TK_TEXT, c, !in_run);
          in_run    = 1'b1;
        end
      end
    endcase
    if (count == 2) begin
      second.last = 1'b1;
    end else begin
      first.last = 1'b1;
    end
    if (last) begin
      if (lex_mode == MODE_FIELD) begin
        err = ERR_OPEN_FIELD;
      end else if (lex_mode == MODE_FNAME) begin
        err = ERR_OPEN_FNAME;
      end else if (lex_mode == MODE_RAW) begin
        err = ERR_OPEN_RAW;
      end else if (overflow) begin
        err = ERR_OVERFLOW;
      end else if (nest_depth != 0) begin
        err = ERR_UNCLOSED;
      end else begin
        err = ERR_NONE;
      end
      first.err  = err;
      second.err = err;
      clear_lexer();
    end
    token_queue.insert(token_queue.size(), first);
    if (count == 2) begin
      token_queue.insert(token_queue.size(), second);
    end
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch in %s: got %0d, expected %0d", field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    token_t want;
    if (!rst_n) begin
      clear_lexer();
      token_queue.delete();
      fail_count    = 0;
      expected_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        lex_char(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        if (token_queue.size() == 0) begin
          report_mismatch("result with no token waiting", out_tuser[3:0], -1);
        end else begin
          want = token_queue.pop_front();
          if (out_tuser[3:0] != want.kind)
            report_mismatch("token_kind", out_tuser[3:0], want.kind);
          if (out_tdata[7:0] != want.ch)
            report_mismatch("out_char", out_tdata[7:0], want.ch);
          if (out_tuser[4] != want.start)
            report_mismatch("token_start", out_tuser[4], want.start);
          if (out_tdata[10:8] != want.err)
            report_mismatch("error_code", out_tdata[10:8], want.err);
          if (out_tlast != want.last)
            report_mismatch("run_last", out_tlast, want.last);
          if (out_tdata[15:11] != 5'd0)
            report_mismatch("tdata padding", out_tdata[15:11], 0);
        end
      end
      expected_left <= token_queue.size();
    end
  end

endmodule

// File: tb/title_format_char_lexer_tb.sv
// ----------------------------------------------------------------------------
// Title-format character lexer testbench
// Sends directed strings, a nesting-overflow string and random well-formed
// and broken strings with random gaps on both streams; the token checker
// beside the lexer predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module title_format_char_lexer_tb;
  import tfcl_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int HOLD_CYCLES  = 100;
  localparam int CYCLE_LIMIT  = 500000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        out_tlast;

  int          fail_count;
  int          expected_left;
  int          items_sent   = 0;
  int          cycle_count  = 0;
  bit          tx_burst     = 1'b0;
  bit          rx_burst     = 1'b0;
  bit          hold_off_req = 1'b0;
  logic [7:0]  char_buf[$];

  title_format_char_lexer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  title_format_char_lexer_checker token_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[title_format_char_lexer] ERROR");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
  endtask

  task automatic add_char(input logic [7:0] c);
    char_buf.insert(char_buf.size(), c);
  endtask

  function automatic logic [7:0] any_char();
    logic [7:0] marks[8];
    marks = '{CH_PERCENT, CH_DOLLAR, CH_COMMA, CH_RPAREN,
              CH_QUOTE, CH_LBRACK, CH_RBRACK, CH_LPAREN};
    if ($urandom_range(0, 2) == 0) begin
      return marks[$urandom_range(0, 7)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] char_except(input logic [7:0] closer);
    logic [7:0] b;
    b = any_char();
    while (b == closer) b = any_char();
    return b;
  endfunction

  // Builds one string out of text, fields, functions, raw sections and
  // conditions; some strings are cut short to leave constructs open.
  task automatic build_string();
    int open_funcs;
    int n;
    open_funcs = 0;
    char_buf.delete();
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 7))
        0, 1: begin
          repeat ($urandom_range(1, 4)) add_char(any_char());
        end
        2: begin
          add_char(CH_PERCENT);
          repeat ($urandom_range(0, 3)) add_char(char_except(CH_PERCENT));
          add_char(CH_PERCENT);
        end
        3: begin
          add_char(CH_DOLLAR);
          repeat ($urandom_range(0, 3)) add_char(char_except(CH_LPAREN));
          add_char(CH_LPAREN);
          open_funcs++;
        end
        4: begin
          add_char(open_funcs > 0 ? CH_COMMA : CH_LBRACK);
        end
        5: begin
          if (open_funcs > 0) begin
            add_char(CH_RPAREN);
            open_funcs--;
          end else begin
            add_char(CH_RBRACK);
          end
        end
        6: begin
          add_char(CH_QUOTE);
          repeat ($urandom_range(0, 3)) add_char(char_except(CH_QUOTE));
          add_char(CH_QUOTE);
        end
        default: begin
          add_char(CH_LBRACK);
          add_char(char_except(CH_QUOTE));
          add_char(CH_RBRACK);
        end
      endcase
    end
    repeat (open_funcs) add_char(CH_RPAREN);
    if ($urandom_range(0, 5) == 0) begin
      n = $urandom_range(0, char_buf.size() - 1);
      repeat (n) void'(char_buf.pop_back());
    end
  endtask

  initial begin
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_tready <= 1'b1;
        do @(posedge clk); while (!out_tvalid);
      end
    end
  end

  initial begin
    string directed[$];
    int    strings_sent;
    directed = '{"''", "%%", "$(,)", ",)", "'%'", "[%'%]",
                 "%", "$a", "'", "$("};
    strings_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_text(directed[i]);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    pause_until_drained();

    // One more opening than the depth counter can hold.
    repeat (256) begin
      send_char(CH_DOLLAR, 1'b0);
      send_char(CH_LPAREN, 1'b0);
    end
    send_char(CH_RPAREN, 1'b1);
    pause_until_drained();

    while (items_sent < RANDOM_ITEMS) begin
      tx_burst = (strings_sent < 6) || ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if (strings_sent == 0) hold_off_req = 1'b1;
      build_string();
      foreach (char_buf[i]) send_char(char_buf[i], i == char_buf.size() - 1);
      if ($urandom_range(0, 9) == 0) pause_until_drained();
      strings_sent++;
    end

    pause_until_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[title_format_char_lexer] OK");
    end else begin
      $display("[title_format_char_lexer] ERROR");
    end
    $finish;
  end

endmodule
